### src/hcbd_pkg.sv
package hcbd_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam logic [1:0] ST_PROGRESS  = 2'd0;
    localparam logic [1:0] ST_ZERO_END  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_SIZE    = 5'b00001,
        PH_SIZE_CR = 5'b00010,
        PH_DATA    = 5'b00100,
        PH_TRAIL   = 5'b01000,
        PH_DONE    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_present;
        logic       body_last;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex_digit;

    function automatic t_hex_digit hex_decode(input logic [7:0] b);
        t_hex_digit d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d.value = 4'(b - 8'h37);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT) || (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

### src/http_chunked_body_decoder_unit.sv
// Channel  | Handshake          | Payload                                         | Dir
// ---------+--------------------+-------------------------------------------------+----
// body in  | i_valid / o_ready  | i_body_byte, i_end_of_input                     | in
// result   | o_valid / i_ready  | o_payload_byte, o_byte_present, o_body_last,    | out
//          |                    | o_status                                        |
//
// One body byte is taken per cycle while o_ready is high. The byte is parsed in the
// cycle of its request, and its result (if any) is written into the result buffer.
// A two-entry result buffer decouples the sides. o_ready is low whenever both entries are
// occupied, even in a cycle in which the consumer takes one, so a stalled consumer holds
// off the input once two results wait; no byte is taken then, even one with no result.
// Reset (synchronous, active low) returns the parser to the start of a size line and
// empties the result buffer.
module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_byte_present,
    output logic       o_body_last,
    output logic [1:0] o_status
);
    import hcbd_pkg::*;

    // Parser state. r_size holds the size while the size line is read, and the number of
    // payload bytes still to come while the chunk data is passed through.
    t_phase               r_phase,      n_phase;
    logic [SIZE_BITS-1:0] r_size,       n_size;
    logic                 r_started,    n_started;
    logic                 r_stopped,    n_stopped;
    logic                 r_overflowed, n_overflowed;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_res_valid;
    t_result              w_res;
    t_result              w_out;

    logic [SIZE_BITS-1:0] w_acc_size;
    logic                 w_acc_started;
    logic                 w_acc_stopped;
    logic                 w_acc_overflowed;

    logic                 w_is_eol;
    logic [SIZE_BITS-1:0] w_one;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = !w_full;
    assign w_is_eol = (i_body_byte == CH_CR) || (i_body_byte == CH_LF);
    assign w_one    = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    // Hex accumulation for a size line byte. Its output is used only when the byte
    // actually lands in the size line phase; the size and flags feeding it are the
    // ones valid at that point, which for a fresh line after the trailer are cleared.
    logic                 w_fresh_line;
    logic [SIZE_BITS-1:0] w_acc_in_size;
    logic                 w_acc_in_started;
    logic                 w_acc_in_stopped;

    assign w_fresh_line     = (r_phase == PH_TRAIL) && !w_is_eol;
    assign w_acc_in_size    = w_fresh_line ? '0 : r_size;
    assign w_acc_in_started = w_fresh_line ? 1'b0 : r_started;
    assign w_acc_in_stopped = w_fresh_line ? 1'b0 : r_stopped;

    hcbd_size_acc #(
        .SIZE_BITS (SIZE_BITS)
    ) u_size_acc (
        .i_byte       (i_body_byte),
        .i_size       (w_acc_in_size),
        .i_started    (w_acc_in_started),
        .i_stopped    (w_acc_in_stopped),
        .i_overflowed (r_overflowed),
        .o_size       (w_acc_size),
        .o_started    (w_acc_started),
        .o_stopped    (w_acc_stopped),
        .o_overflowed (w_acc_overflowed)
    );

    // Byte parse. The phases are tried in order, as one byte may leave one phase and be
    // handled by the next: the byte after a CR that is not LF is payload, and the first
    // byte after the trailing CR/LF run opens the next size line.
    always_comb begin
        logic   v_consumed;
        logic   v_present;
        logic   v_ended;
        t_phase v_phase;

        v_consumed   = 1'b0;
        v_present    = 1'b0;
        v_ended      = 1'b0;
        v_phase      = r_phase;
        n_phase      = r_phase;
        n_size       = r_size;
        n_started    = r_started;
        n_stopped    = r_stopped;
        n_overflowed = r_overflowed;
        w_res_valid  = 1'b0;
        w_res        = '0;

        if (r_phase == PH_DONE) begin
            // Absorbing state after a zero chunk: only an end of input rearms.
            if (i_end_of_input) begin
                n_phase      = PH_SIZE;
                n_size       = '0;
                n_started    = 1'b0;
                n_stopped    = 1'b0;
                n_overflowed = 1'b0;
            end
        end else begin
            if (v_phase == PH_SIZE_CR) begin
                v_phase = PH_DATA;
                if (i_body_byte == CH_LF) begin
                    v_consumed = 1'b1;
                end
            end
            if (!v_consumed && v_phase == PH_TRAIL) begin
                if (w_is_eol) begin
                    v_consumed = 1'b1;
                end else begin
                    v_phase   = PH_SIZE;
                    n_size    = '0;
                    n_started = 1'b0;
                    n_stopped = 1'b0;
                end
            end
            if (!v_consumed && v_phase == PH_DATA) begin
                v_present  = 1'b1;
                v_consumed = 1'b1;
                if (r_size != '0) begin
                    n_size = r_size - w_one;
                end
                if ((r_size == '0) || (r_size == w_one)) begin
                    v_phase = PH_TRAIL;
                end
            end
            if (!v_consumed && v_phase == PH_SIZE) begin
                if (w_is_eol) begin
                    if (n_size == '0) begin
                        v_ended = 1'b1;
                    end else if (i_body_byte == CH_CR) begin
                        v_phase = PH_SIZE_CR;
                    end else begin
                        v_phase = PH_DATA;
                    end
                end else begin
                    n_size       = w_acc_size;
                    n_started    = w_acc_started;
                    n_stopped    = w_acc_stopped;
                    n_overflowed = w_acc_overflowed;
                end
            end

            w_res.payload_byte = v_present ? i_body_byte : 8'd0;
            w_res.byte_present = v_present;
            w_res.body_last    = v_ended || i_end_of_input;
            if (n_overflowed) begin
                w_res.status = ST_OVERFLOW;
            end else if (v_ended) begin
                w_res.status = ST_ZERO_END;
            end else if (i_end_of_input) begin
                w_res.status = ST_TRUNCATED;
            end else begin
                w_res.status = ST_PROGRESS;
            end
            w_res_valid = v_present || v_ended || i_end_of_input;

            n_phase = v_phase;
            if (i_end_of_input) begin
                n_phase      = PH_SIZE;
                n_size       = '0;
                n_started    = 1'b0;
                n_stopped    = 1'b0;
                n_overflowed = 1'b0;
            end else if (v_ended) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_size       <= '0;
            r_started    <= 1'b0;
            r_stopped    <= 1'b0;
            r_overflowed <= 1'b0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_size       <= n_size;
            r_started    <= n_started;
            r_stopped    <= n_stopped;
            r_overflowed <= n_overflowed;
        end
    end

    hcbd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept && w_res_valid),
        .i_result (w_res),
        .o_full   (w_full),
        .o_valid  (o_valid),
        .i_pop    (i_ready),
        .o_result (w_out)
    );

    assign o_payload_byte = w_out.payload_byte;
    assign o_byte_present = w_out.byte_present;
    assign o_body_last    = w_out.body_last;
    assign o_status       = w_out.status;

    a_done_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase == PH_DONE) |-> !w_res_valid)
        else $error("result produced after the zero chunk");

    a_eoi_ends_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_end_of_input && r_phase != PH_DONE) |-> (w_res_valid && w_res.body_last))
        else $error("end of input did not close the body");

    a_eoi_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_end_of_input) |=> (r_phase == PH_SIZE && r_size == '0 && !r_overflowed))
        else $error("parser not rearmed after end of input");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_overflowed && w_res_valid) |-> (w_res.status == ST_OVERFLOW))
        else $error("overflowed body reported without overflow status");

endmodule

### src/hcbd_size_acc.sv
module hcbd_size_acc #(
    parameter int SIZE_BITS = 32
) (
    input  logic [7:0]           i_byte,
    input  logic [SIZE_BITS-1:0] i_size,
    input  logic                 i_started,
    input  logic                 i_stopped,
    input  logic                 i_overflowed,
    output logic [SIZE_BITS-1:0] o_size,
    output logic                 o_started,
    output logic                 o_stopped,
    output logic                 o_overflowed
);
    import hcbd_pkg::*;

    t_hex_digit w_digit;
    logic       w_top_busy;

    assign w_digit    = hex_decode(i_byte);
    // Shifting in one more digit overflows exactly when the top nibble is nonzero.
    assign w_top_busy = |i_size[SIZE_BITS-1 -: 4];

    always_comb begin
        o_size       = i_size;
        o_started    = i_started;
        o_stopped    = i_stopped;
        o_overflowed = i_overflowed;
        if (w_digit.valid && !i_stopped) begin
            o_started = 1'b1;
            if (w_top_busy) begin
                o_size       = '1;
                o_overflowed = 1'b1;
            end else begin
                o_size = {i_size[SIZE_BITS-5:0], w_digit.value};
            end
        end else if (is_blank(i_byte) && !i_started && !i_stopped) begin
            o_stopped = i_stopped;
        end else begin
            o_stopped = 1'b1;
        end
    end

endmodule

### src/hcbd_out_fifo.sv
module hcbd_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hcbd_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output hcbd_pkg::t_result o_result
);
    import hcbd_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_pop_ok;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign w_pop_ok = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop_ok) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full result buffer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    a_ptrs_track_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("result buffer pointers disagree with count");

endmodule
